// ===== rtl/tsbd_pkg.sv =====
// tsbd_pkg: shared types and constants of the token string byte decoder
// no dependencies; imported by every rtl module of the block

package tsbd_pkg;

   typedef logic [7:0] byte_type;

   // up to three bytes with a fill count, used for held bytes and for results
   typedef struct packed {
      logic [1:0]          count;
      byte_type [2:0]      bytes;
   } seq_type;

   typedef enum logic {
      FMT_BPE = 1'b0,
      FMT_SP  = 1'b1
   } fmt_type;

   localparam int       SEQ_MAX       = 3;

   localparam byte_type MARK_B0       = 8'hE2;
   localparam byte_type MARK_B1       = 8'h96;
   localparam byte_type MARK_B2       = 8'h81;
   localparam byte_type SPACE_BYTE    = 8'h20;

   localparam byte_type ASCII_LIM     = 8'h80;
   localparam byte_type LEAD2_MASK    = 8'hE0;
   localparam byte_type LEAD2_CODE    = 8'hC0;
   localparam byte_type LEAD3_MASK    = 8'hF0;
   localparam byte_type LEAD3_CODE    = 8'hE0;
   localparam byte_type LEAD4_MASK    = 8'hF8;
   localparam byte_type LEAD4_CODE    = 8'hF0;

   localparam logic [20:0] CP_MAP_LO  = 21'h00100;
   localparam logic [20:0] CP_MAP_HI  = 21'h00143;
   localparam logic [20:0] CP_BYTE_HI = 21'h000FF;
   localparam logic [20:0] CP_TWO_LIM = 21'h00800;
   localparam logic [20:0] CP_3B_LIM  = 21'h10000;

endpackage

// ===== rtl/tsbd_req_if.sv =====
// tsbd_req_if: request channel of the token string byte decoder
// valid/ready handshake with one string byte and its end flag; no dependencies

interface tsbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== rtl/tsbd_rsp_if.sv =====
// tsbd_rsp_if: response channel of the token string byte decoder
// valid/ready handshake with one text byte and its last flag; no dependencies

interface tsbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/tsbd_decode.sv =====
// tsbd_decode: single-pass decode of held bytes plus one new byte
// depends on tsbd_pkg; produces up to three text bytes and the bytes left held

module tsbd_decode import tsbd_pkg::*; (
   input  fmt_type  fmt,
   input  seq_type  pend,
   input  byte_type in_byte,
   input  logic     eos,
   output seq_type  result,
   output seq_type  next_pend
);

   function automatic logic [2:0] lead_width(input byte_type b);
      logic [2:0] w;
      if (b < ASCII_LIM) begin
         w = 3'd1;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         w = 3'd2;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         w = 3'd3;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         w = 3'd4;
      end else begin
         w = 3'd0;
      end
      return w;
   endfunction

   function automatic byte_type inverse_map(input logic [6:0] idx);
      byte_type r;
      if (idx <= 7'd32) begin
         r = {1'b0, idx};
      end else if (idx == 7'd33) begin
         r = 8'h7F;
      end else if (idx <= 7'd66) begin
         r = {1'b0, idx} + 8'd94;
      end else begin
         r = 8'hAD;
      end
      return r;
   endfunction

   function automatic logic [20:0] decode_point(input byte_type b0, input byte_type b1,
                                                input byte_type b2, input byte_type b3,
                                                input logic [2:0] w);
      logic [20:0] cp;
      case (w)
         3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
         3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
         default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      endcase
      return cp;
   endfunction

   function automatic seq_type emit_point(input logic [20:0] cp);
      seq_type s;
      logic [20:0] off;
      s   = '0;
      off = cp - CP_MAP_LO;
      if (cp >= CP_MAP_LO && cp <= CP_MAP_HI) begin
         s.count    = 2'd1;
         s.bytes[0] = inverse_map(off[6:0]);
      end else if (cp <= CP_BYTE_HI) begin
         s.count    = 2'd1;
         s.bytes[0] = cp[7:0];
      end else if (cp < CP_TWO_LIM) begin
         s.count    = 2'd2;
         s.bytes[0] = {3'b110, cp[10:6]};
         s.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < CP_3B_LIM) begin
         s.count    = 2'd3;
         s.bytes[0] = {4'b1110, cp[15:12]};
         s.bytes[1] = {2'b10, cp[11:6]};
         s.bytes[2] = {2'b10, cp[5:0]};
      end
      return s;
   endfunction

   always_comb begin
      byte_type    held [4];
      seq_type     emit;
      logic [2:0]  n;
      logic [2:0]  i;
      logic [2:0]  rem;
      logic [2:0]  adv;
      logic [2:0]  w;
      logic [2:0]  pos;
      logic [1:0]  k;
      logic        stop;
      byte_type    b0;
      byte_type    b1;
      byte_type    b2;
      byte_type    b3;

      for (int h = 0; h < SEQ_MAX; h++) begin
         held[h] = (2'(h) < pend.count) ? pend.bytes[h] : in_byte;
      end
      held[3] = in_byte;

      n      = {1'b0, pend.count} + 3'd1;
      i      = 3'd0;
      k      = 2'd0;
      stop   = 1'b0;
      result = '0;

      for (int s = 0; s < 4; s++) begin
         emit = '0;
         adv  = 3'd0;
         w    = 3'd0;
         rem  = n - i;
         b0   = held[i[1:0]];
         b1   = held[i[1:0] + 2'd1];
         b2   = held[i[1:0] + 2'd2];
         b3   = held[i[1:0] + 2'd3];
         if (!stop && i < n) begin
            if (fmt == FMT_BPE) begin
               w = lead_width(b0);
               if (w <= 3'd1) begin
                  emit.count    = 2'd1;
                  emit.bytes[0] = b0;
                  adv           = 3'd1;
               end else if (w <= rem) begin
                  emit = emit_point(decode_point(b0, b1, b2, b3, w));
                  adv  = w;
               end else if (eos) begin
                  emit.count    = 2'd1;
                  emit.bytes[0] = b0;
                  adv           = 3'd1;
               end else begin
                  stop = 1'b1;
               end
            end else begin
               if (b0 != MARK_B0 || (rem > 3'd1 && b1 != MARK_B1) ||
                   (rem > 3'd2 && b2 != MARK_B2)) begin
                  emit.count    = 2'd1;
                  emit.bytes[0] = b0;
                  adv           = 3'd1;
               end else if (rem >= 3'd3) begin
                  emit.count    = 2'd1;
                  emit.bytes[0] = SPACE_BYTE;
                  adv           = 3'd3;
               end else if (eos) begin
                  emit.count    = 2'd1;
                  emit.bytes[0] = b0;
                  adv           = 3'd1;
               end else begin
                  stop = 1'b1;
               end
            end
         end
         for (int m = 0; m < SEQ_MAX; m++) begin
            if (2'(m) < emit.count && k != 2'd3) begin
               result.bytes[k] = emit.bytes[m];
               k = k + 2'd1;
            end
         end
         i = i + adv;
      end

      result.count    = k;
      next_pend.count = 2'(n - i);
      for (int h = 0; h < SEQ_MAX; h++) begin
         pos                = i + 3'(h);
         next_pend.bytes[h] = held[pos[1:0]];
      end
   end

endmodule

// ===== rtl/tsbd_rsp_buf.sv =====
// tsbd_rsp_buf: result register that hands out up to three bytes one at a time
// depends on tsbd_pkg and tsbd_rsp_if

module tsbd_rsp_buf import tsbd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  seq_type           load_data,
   output logic              can_load,
   tsbd_rsp_if.source        rsp_chan
);

   seq_type buf_ff, buf_in;
   logic    take;

   assign take              = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid    = (buf_ff.count != 2'd0);
   assign rsp_chan.out_byte = buf_ff.bytes[0];
   assign rsp_chan.run_last = (buf_ff.count == 2'd1);
   assign can_load          = (buf_ff.count == 2'd0) ||
                              (buf_ff.count == 2'd1 && rsp_chan.ready);

   always_comb begin
      buf_in = buf_ff;
      if (load) begin
         buf_in = load_data;
      end else if (take) begin
         buf_in.count    = buf_ff.count - 2'd1;
         buf_in.bytes[0] = buf_ff.bytes[1];
         buf_in.bytes[1] = buf_ff.bytes[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
      end else begin
         buf_ff <= buf_in;
      end
   end

endmodule

// ===== rtl/token_string_byte_decoder.sv =====
// token_string_byte_decoder: top level, input register, held-byte state, mode register
// depends on tsbd_pkg, tsbd_req_if, tsbd_rsp_if, tsbd_decode, tsbd_rsp_buf
//
//   port      dir   handshake      carries
//   req_chan  in    valid/ready    in_byte, end_of_string
//   rsp_chan  out   valid/ready    out_byte, run_last
//   csr_*     in    csr_we         csr_wdata (decode_format)
//
// a request passes through the input register and then through the result register
// a request with k results (k = 0 to 3) holds the result register until all k are taken,
// so requests with at most one result flow at one per cycle while rsp ready is high
// reset is synchronous and clears the valid flags, the mode and the held-byte count
// a stalled response backs up into the input register and then drops req ready

module token_string_byte_decoder import tsbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tsbd_req_if.sink    req_chan,
   tsbd_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;
   logic     in_eos_ff;
   fmt_type  fmt_ff;
   seq_type  pend_ff, pend_in;
   seq_type  result;
   seq_type  next_pend;
   logic     can_load;
   logic     fire;
   logic     req_take;

   assign fire           = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (csr_we) begin
         pend_in = '0;
      end else if (fire) begin
         pend_in = next_pend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         fmt_ff      <= FMT_BPE;
         pend_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pend_ff     <= pend_in;
         if (csr_we) begin
            fmt_ff <= fmt_type'(csr_wdata);
         end
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.in_byte;
         in_eos_ff  <= req_chan.end_of_string;
      end
   end

   tsbd_decode u_decode (
      .fmt       (fmt_ff),
      .pend      (pend_ff),
      .in_byte   (in_byte_ff),
      .eos       (in_eos_ff),
      .result    (result),
      .next_pend (next_pend)
   );

   tsbd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (result),
      .can_load  (can_load),
      .rsp_chan  (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_eos_flushes: assert property (@(posedge clock) disable iff (reset)
      fire && in_eos_ff |=> pend_ff.count == 2'd0)
      else $error("held bytes left after end of string");

   a_sp_hold_max: assert property (@(posedge clock) disable iff (reset)
      fire && fmt_ff == FMT_SP |=> pend_ff.count != 2'd3)
      else $error("word marker mode holds three bytes");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eos_ff))
      else $error("blocked request lost from input register");
`endif

endmodule
